// ----- hw/rtl/lfrr_pkg.sv -----
// ----------------------------------------------------------------------------
// lfrr_pkg
// Shared types and constants for the line follower record/replay block.
// ----------------------------------------------------------------------------
package lfrr_pkg;

  localparam int unsigned StampW  = 32;
  localparam int unsigned StateW  = 3;
  localparam int unsigned EntryW  = StampW + StateW;
  localparam int unsigned LapW    = 8;
  localparam int unsigned ThreshW = 10;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 10;

  localparam logic [LapW-1:0]    LapLimitRst  = 8'd3;
  localparam logic [ThreshW-1:0] ThresholdRst = 10'd0;
  localparam logic [DutyW-1:0]   TurnDutyRst  = 8'hE0;

  typedef enum logic [StateW-1:0] {
    ST_STANDBY   = 3'd0,
    ST_FORWARD   = 3'd1,
    ST_LEFT      = 3'd2,
    ST_RIGHT     = 3'd3,
    ST_LAP       = 3'd4,
    ST_LAP_LEFT  = 3'd5,
    ST_LAP_RIGHT = 3'd6,
    ST_STOPPED   = 3'd7
  } drive_state_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_STEP  = 2'd1,
    OP_START = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    LM_OFF = 2'd0,
    LM_ON  = 2'd1,
    LM_PWM = 2'd2
  } left_mode_e;

  typedef enum logic {
    RM_OFF = 1'b0,
    RM_ON  = 1'b1
  } right_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LAP_LIMIT = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_TURN_DUTY = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [StampW-1:0] stamp;
    drive_state_e      state;
  } log_entry_t;

  typedef struct packed {
    logic [LapW-1:0]  lap_count;
    logic             replay_mode;
    logic [DutyW-1:0] pwm_duty;
    right_mode_e      right_mode;
    left_mode_e       left_mode;
    drive_state_e     drive_state;
  } result_t;

endpackage

// ----- hw/rtl/lfrr_ram.sv -----
// ----------------------------------------------------------------------------
// lfrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfrr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/lfrr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfrr_ctrl
// Drive state machine, lap counter, timer and change log with replay.
// ----------------------------------------------------------------------------
module lfrr_ctrl #(
  parameter int unsigned LogDepth = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfrr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [lfrr_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                            accept_i,
  input  logic [1:0]                      op_i,
  input  logic                            left_black_i,
  input  logic                            middle_black_i,
  input  logic                            right_black_i,
  input  logic [lfrr_pkg::ThreshW-1:0]    sample_i,
  output lfrr_pkg::result_t               result_o
);

  localparam int unsigned AddrW = $clog2(LogDepth);
  localparam int unsigned CntW  = $clog2(LogDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(LogDepth);

  logic [lfrr_pkg::LapW-1:0]    lap_limit_q;
  logic [lfrr_pkg::ThreshW-1:0] threshold_q;
  logic [lfrr_pkg::DutyW-1:0]   turn_duty_q;

  lfrr_pkg::drive_state_e       mode_q, mode_d;
  logic                         replay_q, replay_d;
  logic [lfrr_pkg::LapW-1:0]    laps_q, laps_d;
  logic [lfrr_pkg::StampW-1:0]  elapsed_q, elapsed_d;
  logic [CntW-1:0]              wr_idx_q, wr_idx_d;
  logic [CntW-1:0]              rd_idx_q, rd_idx_d;

  logic                         enter;
  lfrr_pkg::drive_state_e       enter_st;
  logic                         log_we;
  lfrr_pkg::log_entry_t         wr_entry, rd_entry;
  logic [lfrr_pkg::EntryW-1:0]  rd_raw;
  logic                         l, m, r;
  logic                         lap_hit;

  assign l = left_black_i;
  assign m = middle_black_i;
  assign r = right_black_i;
  assign lap_hit = (laps_q == lap_limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lap_limit_q <= lfrr_pkg::LapLimitRst;
      threshold_q <= lfrr_pkg::ThresholdRst;
      turn_duty_q <= lfrr_pkg::TurnDutyRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lfrr_pkg::CFG_LAP_LIMIT: lap_limit_q <= cfg_data_i[lfrr_pkg::LapW-1:0];
        lfrr_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i[lfrr_pkg::ThreshW-1:0];
        lfrr_pkg::CFG_TURN_DUTY: turn_duty_q <= cfg_data_i[lfrr_pkg::DutyW-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    mode_d    = mode_q;
    replay_d  = replay_q;
    laps_d    = laps_q;
    elapsed_d = elapsed_q;
    wr_idx_d  = wr_idx_q;
    rd_idx_d  = rd_idx_q;
    enter     = 1'b0;
    enter_st  = mode_q;
    log_we    = 1'b0;
    if (accept_i) begin
      unique case (op_i)
        lfrr_pkg::OP_TICK: begin
          elapsed_d = elapsed_q + 1'b1;
        end
        lfrr_pkg::OP_STEP: begin
          if (replay_q) begin
            if (rd_idx_q >= wr_idx_q || rd_idx_q >= DepthCnt) begin
              mode_d = lfrr_pkg::ST_STOPPED;
            end else if (elapsed_q > rd_entry.stamp) begin
              mode_d   = rd_entry.state;
              rd_idx_d = rd_idx_q + 1'b1;
            end
          end else begin
            unique case (mode_q)
              lfrr_pkg::ST_FORWARD: begin
                if (m) begin
                  if (l && r) begin
                    enter    = 1'b1;
                    enter_st = lfrr_pkg::ST_LAP;
                    laps_d   = laps_q + 1'b1;
                  end
                end else if (l) begin
                  enter    = 1'b1;
                  enter_st = lfrr_pkg::ST_LEFT;
                end else if (r) begin
                  enter    = 1'b1;
                  enter_st = lfrr_pkg::ST_RIGHT;
                end
              end
              lfrr_pkg::ST_LEFT, lfrr_pkg::ST_RIGHT: begin
                if (m) begin
                  enter    = 1'b1;
                  enter_st = lfrr_pkg::ST_FORWARD;
                end
              end
              lfrr_pkg::ST_LAP, lfrr_pkg::ST_LAP_LEFT, lfrr_pkg::ST_LAP_RIGHT: begin
                if (lap_hit) begin
                  mode_d    = lfrr_pkg::ST_STOPPED;
                  replay_d  = 1'b1;
                  elapsed_d = '0;
                end else if (m) begin
                  if (!l && !r) begin
                    enter    = 1'b1;
                    enter_st = lfrr_pkg::ST_FORWARD;
                  end else if (mode_q == lfrr_pkg::ST_LAP) begin
                    if (!l) begin
                      enter    = 1'b1;
                      enter_st = lfrr_pkg::ST_LAP_RIGHT;
                    end else if (!r) begin
                      enter    = 1'b1;
                      enter_st = lfrr_pkg::ST_LAP_LEFT;
                    end
                  end else if (l && r) begin
                    enter    = 1'b1;
                    enter_st = lfrr_pkg::ST_LAP;
                  end
                end else if (l) begin
                  enter    = 1'b1;
                  enter_st = lfrr_pkg::ST_LEFT;
                end else if (r) begin
                  enter    = 1'b1;
                  enter_st = lfrr_pkg::ST_RIGHT;
                end
              end
              default: ;
            endcase
          end
        end
        lfrr_pkg::OP_START: begin
          if (mode_q == lfrr_pkg::ST_STANDBY && sample_i > threshold_q) begin
            mode_d = lfrr_pkg::ST_FORWARD;
          end
        end
        default: ;
      endcase
      if (enter) begin
        mode_d = enter_st;
        if (wr_idx_q < DepthCnt) begin
          log_we   = 1'b1;
          wr_idx_d = wr_idx_q + 1'b1;
        end
      end
    end
  end

  // Result outputs
  always_comb begin
    result_o             = '0;
    result_o.drive_state = mode_d;
    result_o.replay_mode = replay_d;
    result_o.lap_count   = laps_d;
    result_o.left_mode   = lfrr_pkg::LM_OFF;
    result_o.right_mode  = lfrr_pkg::RM_OFF;
    unique case (mode_d)
      lfrr_pkg::ST_FORWARD, lfrr_pkg::ST_LAP: begin
        result_o.left_mode  = lfrr_pkg::LM_ON;
        result_o.right_mode = lfrr_pkg::RM_ON;
      end
      lfrr_pkg::ST_LEFT, lfrr_pkg::ST_LAP_LEFT: begin
        result_o.right_mode = lfrr_pkg::RM_ON;
      end
      lfrr_pkg::ST_RIGHT, lfrr_pkg::ST_LAP_RIGHT: begin
        result_o.left_mode = lfrr_pkg::LM_PWM;
        result_o.pwm_duty  = turn_duty_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= lfrr_pkg::ST_STANDBY;
      replay_q  <= 1'b0;
      laps_q    <= '0;
      elapsed_q <= '0;
      wr_idx_q  <= '0;
      rd_idx_q  <= '0;
    end else begin
      mode_q    <= mode_d;
      replay_q  <= replay_d;
      laps_q    <= laps_d;
      elapsed_q <= elapsed_d;
      wr_idx_q  <= wr_idx_d;
      rd_idx_q  <= rd_idx_d;
    end
  end

  // Log is only written before replay starts, and the beat that starts replay
  // writes nothing, so the prefetched entry at rd_idx_q is always current.
  assign wr_entry.stamp = elapsed_q;
  assign wr_entry.state = enter_st;
  assign rd_entry       = lfrr_pkg::log_entry_t'(rd_raw);

  lfrr_ram #(
    .Width (lfrr_pkg::EntryW),
    .Depth (LogDepth)
  ) u_log (
    .clk_i   (clk_i),
    .we_i    (log_we),
    .waddr_i (wr_idx_q[AddrW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (rd_idx_d[AddrW-1:0]),
    .rdata_o (rd_raw)
  );

endmodule

// ----- hw/rtl/lfrr_out_buf.sv -----
// ----------------------------------------------------------------------------
// lfrr_out_buf
// Output register with skid stage for result beats.
// ----------------------------------------------------------------------------
module lfrr_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lfrr_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lfrr_pkg::result_t out_data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  lfrr_pkg::result_t out_data_q, out_data_d;
  lfrr_pkg::result_t skid_data_q, skid_data_d;
  logic              push, pop;

  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && !skid_valid_q;
  assign pop        = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_d = 1'b1;
        out_data_d  = in_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = in_data_i;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- hw/rtl/line_follower_record_replay.sv -----
// ----------------------------------------------------------------------------
// line_follower_record_replay
// Line-following drive controller that logs state changes and replays them.
// ----------------------------------------------------------------------------
// Input beats on s_axis: tuser carries the op (timer tick, control step,
// start sample), tdata the three sensor bits and the start sample. Every
// input beat yields exactly one result beat on m_axis with the drive state,
// motor modes, pwm duty and lap count; tuser flags replay mode.
// Registers (lap limit, start threshold, turn duty) are written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only while no
// beat is in flight, which the block itself does not enforce. One beat per
// cycle sustained while m_axis_tready stays high. The change log is a
// single-port-write, registered-read RAM of LOG_DEPTH entries; the entry at
// the replay pointer is prefetched every cycle so a control step uses it
// without waiting. A two-entry output stage (register plus skid) decouples
// the sides: input keeps flowing while one result waits; s_axis_tready drops
// only when both entries are full.
// Reset puts the block in standby with zero laps, zero time and an empty log;
// registers return to lap limit 3, threshold 0, duty 0xE0. No clearing pass.
// ----------------------------------------------------------------------------
module line_follower_record_replay #(
  parameter int unsigned LOG_DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lfrr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lfrr_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,  // left_black, middle_black,
                                                      // right_black, sample, pad
  input  logic [1:0]                   s_axis_tuser,  // op
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,  // drive_state, left_mode,
                                                      // right_mode, pwm_duty,
                                                      // lap_count, pad
  output logic                         m_axis_tuser   // replay_mode
);

  logic              accept;
  lfrr_pkg::result_t res, res_out;

  assign accept = s_axis_tvalid && s_axis_tready;

  lfrr_ctrl #(
    .LogDepth (LOG_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .op_i           (s_axis_tuser),
    .left_black_i   (s_axis_tdata[0]),
    .middle_black_i (s_axis_tdata[1]),
    .right_black_i  (s_axis_tdata[2]),
    .sample_i       (s_axis_tdata[12:3]),
    .result_o       (res)
  );

  lfrr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res_out)
  );

  assign m_axis_tdata = {2'b00, res_out.lap_count, res_out.pwm_duty, res_out.right_mode,
                         res_out.left_mode, res_out.drive_state};
  assign m_axis_tuser = res_out.replay_mode;

endmodule

// ----- bench/tb_line_follower_record_replay.sv -----
// ----------------------------------------------------------------------------
// tb_line_follower_record_replay
// Self-checking bench for the line follower record/replay controller.
// Drives timer ticks, start samples and sensor steps with random idles on
// both stream sides, tracks drive state, lap count and the change log in a
// software model, and checks every result beat in order. The run covers the
// start threshold, all drive transitions, a full log, lap counter wrap, and
// ends with the replay of the recorded log until the block stops.
// ----------------------------------------------------------------------------
module tb_line_follower_record_replay;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LogDepth     = 64;
  localparam int unsigned LogIdxW      = $clog2(LogDepth);
  localparam int unsigned CfgDataW     = lfrr_pkg::CfgW;
  localparam int unsigned SampleW      = lfrr_pkg::ThreshW;
  localparam int unsigned PhaseItems   = 50;
  localparam int unsigned RandomPhases = 4;
  localparam int unsigned StallLimit   = 2000;
  localparam logic [1:0]  OpUnused     = 2'd3;

  class drive_tracker;
    lfrr_pkg::drive_state_e             mode;
    bit                                 replaying;
    logic [lfrr_pkg::LapW-1:0]          laps;
    logic [lfrr_pkg::StampW-1:0]        ticks;
    int unsigned                        wr_idx;
    int unsigned                        rd_idx;
    logic [lfrr_pkg::StampW-1:0]        stamp_log [LogDepth];
    lfrr_pkg::drive_state_e             state_log [LogDepth];
    logic [lfrr_pkg::LapW-1:0]          lap_limit;
    logic [lfrr_pkg::ThreshW-1:0]       threshold;
    logic [lfrr_pkg::DutyW-1:0]         turn_duty;
    lfrr_pkg::result_t                  pending_outputs [$];
    int unsigned                        failures;

    function new();
      mode      = lfrr_pkg::ST_STANDBY;
      replaying = 1'b0;
      laps      = '0;
      ticks     = '0;
      wr_idx    = 0;
      rd_idx    = 0;
      lap_limit = lfrr_pkg::LapLimitRst;
      threshold = lfrr_pkg::ThresholdRst;
      turn_duty = lfrr_pkg::TurnDutyRst;
      failures  = 0;
    endfunction

    function void write_reg(lfrr_pkg::cfg_idx_e idx, logic [lfrr_pkg::CfgW-1:0] value);
      case (idx)
        lfrr_pkg::CFG_LAP_LIMIT: lap_limit = value[lfrr_pkg::LapW-1:0];
        lfrr_pkg::CFG_THRESHOLD: threshold = value[lfrr_pkg::ThreshW-1:0];
        lfrr_pkg::CFG_TURN_DUTY: turn_duty = value[lfrr_pkg::DutyW-1:0];
        default: ;
      endcase
    endfunction

    function void log_change(lfrr_pkg::drive_state_e next);
      mode = next;
      if (wr_idx < LogDepth) begin
        stamp_log[LogIdxW'(wr_idx)] = ticks;
        state_log[LogIdxW'(wr_idx)] = next;
        wr_idx++;
      end
    endfunction

    function void replay_next();
      if (rd_idx >= wr_idx) begin
        mode = lfrr_pkg::ST_STOPPED;
      end else if (ticks > stamp_log[LogIdxW'(rd_idx)]) begin
        mode = state_log[LogIdxW'(rd_idx)];
        rd_idx++;
      end
    endfunction

    function bit lap_limit_hit();
      if (laps != lap_limit) return 1'b0;
      mode      = lfrr_pkg::ST_STOPPED;
      replaying = 1'b1;
      ticks     = '0;
      return 1'b1;
    endfunction

    function void track_line(logic l, logic m, logic r);
      case (mode)
        lfrr_pkg::ST_FORWARD: begin
          if (m) begin
            if (l && r) begin
              log_change(lfrr_pkg::ST_LAP);
              laps++;
            end
          end else if (l) begin
            log_change(lfrr_pkg::ST_LEFT);
          end else if (r) begin
            log_change(lfrr_pkg::ST_RIGHT);
          end
        end
        lfrr_pkg::ST_LEFT, lfrr_pkg::ST_RIGHT: begin
          if (m) log_change(lfrr_pkg::ST_FORWARD);
        end
        lfrr_pkg::ST_LAP: begin
          if (!lap_limit_hit()) begin
            if (m) begin
              if (!l && !r) log_change(lfrr_pkg::ST_FORWARD);
              else if (!l && r) log_change(lfrr_pkg::ST_LAP_RIGHT);
              else if (l && !r) log_change(lfrr_pkg::ST_LAP_LEFT);
            end else if (l) begin
              log_change(lfrr_pkg::ST_LEFT);
            end else if (r) begin
              log_change(lfrr_pkg::ST_RIGHT);
            end
          end
        end
        lfrr_pkg::ST_LAP_LEFT, lfrr_pkg::ST_LAP_RIGHT: begin
          if (!lap_limit_hit()) begin
            if (m) begin
              if (l && r) log_change(lfrr_pkg::ST_LAP);
              else if (!l && !r) log_change(lfrr_pkg::ST_FORWARD);
            end else if (l) begin
              log_change(lfrr_pkg::ST_LEFT);
            end else if (r) begin
              log_change(lfrr_pkg::ST_RIGHT);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void accept_event(logic [1:0] op, logic [15:0] data);
      logic                         l, m, r;
      logic [lfrr_pkg::ThreshW-1:0] sample;
      lfrr_pkg::result_t            res;
      l      = data[0];
      m      = data[1];
      r      = data[2];
      sample = data[12:3];
      if (op == lfrr_pkg::OP_TICK) begin
        ticks++;
      end else if (op == lfrr_pkg::OP_STEP) begin
        if (replaying) replay_next();
        else track_line(l, m, r);
      end else if (op == lfrr_pkg::OP_START) begin
        if (mode == lfrr_pkg::ST_STANDBY && sample > threshold) mode = lfrr_pkg::ST_FORWARD;
      end
      res             = '0;
      res.drive_state = mode;
      res.replay_mode = replaying;
      res.lap_count   = laps;
      case (mode)
        lfrr_pkg::ST_FORWARD, lfrr_pkg::ST_LAP: begin
          res.left_mode  = lfrr_pkg::LM_ON;
          res.right_mode = lfrr_pkg::RM_ON;
        end
        lfrr_pkg::ST_LEFT, lfrr_pkg::ST_LAP_LEFT: begin
          res.left_mode  = lfrr_pkg::LM_OFF;
          res.right_mode = lfrr_pkg::RM_ON;
        end
        lfrr_pkg::ST_RIGHT, lfrr_pkg::ST_LAP_RIGHT: begin
          res.left_mode  = lfrr_pkg::LM_PWM;
          res.right_mode = lfrr_pkg::RM_OFF;
          res.pwm_duty   = turn_duty;
        end
        default: begin
          res.left_mode  = lfrr_pkg::LM_OFF;
          res.right_mode = lfrr_pkg::RM_OFF;
        end
      endcase
      pending_outputs.push_back(res);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= 10)
          $display("drive result %s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void match_drive_output(logic [23:0] data, logic user);
      lfrr_pkg::result_t want;
      if (pending_outputs.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result beat with nothing pending: tdata %h", data);
        return;
      end
      want = pending_outputs.pop_front();
      compare_field("drive_state", 8'(want.drive_state), 8'(data[2:0]));
      compare_field("left_mode", 8'(want.left_mode), 8'(data[4:3]));
      compare_field("right_mode", 8'(want.right_mode), 8'(data[5]));
      compare_field("pwm_duty", want.pwm_duty, data[13:6]);
      compare_field("lap_count", want.lap_count, data[21:14]);
      compare_field("replay_mode", 8'(want.replay_mode), 8'(user));
    endfunction

    function int unsigned pending();
      return pending_outputs.size();
    endfunction
  endclass

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [lfrr_pkg::CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [lfrr_pkg::CfgW-1:0]    cfg_data_i    = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [15:0]                  s_axis_tdata  = '0;
  logic [1:0]                   s_axis_tuser  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [23:0]                  m_axis_tdata;
  logic                         m_axis_tuser;

  drive_tracker tracker;
  bit           tx_burst = 1'b0;
  bit           rx_burst = 1'b0;
  int unsigned  stall_cycles = 0;

  line_follower_record_replay #(
    .LOG_DEPTH(LogDepth)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) tracker.match_drive_output(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) tracker.accept_event(s_axis_tuser, s_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("no beat accepted for %0d cycles", StallLimit);
      $display("** line_follower_record_replay: FAILED **");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned gap;
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [15:0] payload);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, payload[12:0]};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // sensor bits given as {left, middle, right}
  task automatic step(input logic [2:0] lmr);
    logic [lfrr_pkg::ThreshW-1:0] junk;
    junk = SampleW'($urandom_range(0, 1023));
    send_beat(lfrr_pkg::OP_STEP, {3'b000, junk, lmr[0], lmr[1], lmr[2]});
  endtask

  task automatic tick();
    send_beat(lfrr_pkg::OP_TICK, 16'($urandom()));
  endtask

  task automatic start_sample(input logic [lfrr_pkg::ThreshW-1:0] sample);
    logic [2:0] junk;
    junk = 3'($urandom_range(0, 7));
    send_beat(lfrr_pkg::OP_START, {3'b000, sample, junk});
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_registers(input logic [lfrr_pkg::LapW-1:0] lap,
                               input logic [lfrr_pkg::ThreshW-1:0] thr,
                               input logic [lfrr_pkg::DutyW-1:0] duty);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= lfrr_pkg::CFG_LAP_LIMIT;
    cfg_data_i <= CfgDataW'(lap);
    tracker.write_reg(lfrr_pkg::CFG_LAP_LIMIT, CfgDataW'(lap));
    @(posedge clk_i);
    cfg_idx_i  <= lfrr_pkg::CFG_THRESHOLD;
    cfg_data_i <= CfgDataW'(thr);
    tracker.write_reg(lfrr_pkg::CFG_THRESHOLD, CfgDataW'(thr));
    @(posedge clk_i);
    cfg_idx_i  <= lfrr_pkg::CFG_TURN_DUTY;
    cfg_data_i <= CfgDataW'(duty);
    tracker.write_reg(lfrr_pkg::CFG_TURN_DUTY, CfgDataW'(duty));
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [lfrr_pkg::ThreshW-1:0] pick_threshold();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return SampleW'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [lfrr_pkg::DutyW-1:0] pick_duty();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // limit must stay out of reach of the laps one phase can add
  function automatic bit lap_limit_safe(input logic [lfrr_pkg::LapW-1:0] cand);
    logic [lfrr_pkg::LapW-1:0] ahead;
    ahead = cand - tracker.laps;
    return (cand != 0) && (ahead > PhaseItems);
  endfunction

  function automatic void pick_idling();
    tx_burst = ($urandom_range(0, 3) == 0);
    rx_burst = ($urandom_range(0, 3) == 0);
  endfunction

  task automatic drive_random_item();
    int unsigned pick;
    int unsigned bias;
    logic [2:0]  lmr;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      tick();
    end else if (pick < 22) begin
      start_sample(SampleW'($urandom_range(0, 1023)));
    end else if (pick < 24) begin
      send_beat(OpUnused, 16'($urandom()));
    end else begin
      lmr  = 3'($urandom_range(0, 7));
      bias = $urandom_range(0, 99);
      if (tracker.mode == lfrr_pkg::ST_FORWARD && bias < 60) begin
        lmr = 3'b111;
      end else if (tracker.mode inside {lfrr_pkg::ST_LAP, lfrr_pkg::ST_LAP_LEFT,
                                        lfrr_pkg::ST_LAP_RIGHT} && bias < 45) begin
        lmr = 3'b010;
      end
      step(lmr);
    end
  endtask

  task automatic replay_run();
    int unsigned count;
    int unsigned tail;
    int unsigned pick;
    count = 0;
    tail  = 0;
    while (tail < 30 && count < 3000) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) tick();
      else if (pick < 90) step(3'($urandom_range(0, 7)));
      else if (pick < 95) start_sample(SampleW'($urandom_range(0, 1023)));
      else send_beat(OpUnused, 16'($urandom()));
      count++;
      if (tracker.mode == lfrr_pkg::ST_STOPPED && tracker.rd_idx >= tracker.wr_idx) tail++;
    end
  endtask

  initial begin : stimulus
    logic [lfrr_pkg::LapW-1:0] limit;
    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // standby handling and the start threshold
    send_beat(OpUnused, 16'h1fff);
    tick();
    start_sample(10'd0);
    step(3'b111);
    settle();
    set_registers(lfrr_pkg::LapLimitRst, 10'd1023, lfrr_pkg::TurnDutyRst);
    start_sample(10'd1023);
    settle();
    set_registers(8'd255, 10'd500, 8'd0);
    start_sample(10'd500);
    start_sample(10'd501);
    start_sample(10'd0);

    // drive transitions
    step(3'b000);
    step(3'b100);
    step(3'b000);
    step(3'b010);
    step(3'b001);
    tick();
    step(3'b110);
    step(3'b111);
    step(3'b011);
    step(3'b111);
    step(3'b110);
    step(3'b001);
    step(3'b010);
    step(3'b111);
    step(3'b000);
    step(3'b101);
    step(3'b010);
    settle();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      limit = (ph == 0) ? 8'd255 : (ph == 1) ? 8'd1 : 8'($urandom_range(1, 255));
      while (!lap_limit_safe(limit)) limit = 8'($urandom_range(1, 255));
      pick_idling();
      set_registers(limit, pick_threshold(), pick_duty());
      repeat (PhaseItems) drive_random_item();
      settle();
    end

    // run the lap counter all the way around without meeting the limit
    step(3'b010);
    settle();
    if (tracker.laps == 0) begin
      step(3'b111);
      step(3'b010);
      settle();
    end
    pick_idling();
    set_registers(tracker.laps, pick_threshold(), pick_duty());
    repeat (255) begin
      step(3'b111);
      step(3'b010);
    end
    settle();

    // hit the limit and play the log back
    pick_idling();
    set_registers(tracker.laps + 8'd1, pick_threshold(), pick_duty());
    step(3'b111);
    step(3'($urandom_range(0, 7)));
    settle();
    pick_idling();
    set_registers(8'($urandom_range(1, 255)), pick_threshold(), pick_duty());
    replay_run();
    settle();
    repeat (20) @(posedge clk_i);

    if (tracker.pending() != 0) $display("%0d results never arrived", tracker.pending());
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("** line_follower_record_replay: PASSED **");
    end else begin
      $display("** line_follower_record_replay: FAILED **");
    end
    $finish;
  end

endmodule
